// ===== hdl/ebml_element_header_parser_defines.svh =====
// Assertion macros used by the parser top level.
`ifndef EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH
`define EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define EHP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ehp assertion failed");

// Check that cons holds in the cycle after ante.
`define EHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ehp assertion failed");

`endif

// ===== hdl/ehp_pkg.sv =====
package ehp_pkg;

    localparam int MAX_ID_OCTETS   = 4;
    localparam int MAX_SIZE_OCTETS = 8;
    localparam int BYTE_W          = 8;
    localparam int ID_W            = 32;
    localparam int SIZE_W          = 56;
    localparam int VINT_BITS       = 7;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_INVALID    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_ID_LEAD   = 2'd0,
        PH_ID_CONT   = 2'd1,
        PH_SIZE_LEAD = 2'd2,
        PH_SIZE_CONT = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]   elem_id;
        logic [SIZE_W-1:0] payload_size;
        logic              size_unknown;
        logic [3:0]        header_length;
        t_status           status;
    } t_out_word;

    function automatic logic [2:0] lead_zeros(input logic [BYTE_W-1:0] b);
        logic [2:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = BYTE_W - 1; i >= 1; i--) begin
            if (!found) begin
                if (b[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 3'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic [SIZE_W-1:0] size_all_ones(input logic [3:0] n);
        logic [SIZE_W-1:0] m;
        case (n)
            4'd1:    m = 56'h00_0000_0000_007F;
            4'd2:    m = 56'h00_0000_0000_3FFF;
            4'd3:    m = 56'h00_0000_001F_FFFF;
            4'd4:    m = 56'h00_0000_0FFF_FFFF;
            4'd5:    m = 56'h00_0007_FFFF_FFFF;
            4'd6:    m = 56'h00_03FF_FFFF_FFFF;
            4'd7:    m = 56'h01_FFFF_FFFF_FFFF;
            default: m = 56'hFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/ehp_in_if.sv =====
interface ehp_in_if;
    import ehp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ehp_out_if.sv =====
interface ehp_out_if;
    import ehp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ehp_decode.sv =====
module ehp_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ehp_pkg::t_in_word i_word,
    output logic              o_res_valid,
    output ehp_pkg::t_out_word o_res
);
    import ehp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [2:0]        r_octets_left, n_octets_left;
    logic [ID_W-1:0]   r_id, n_id;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [3:0]        r_size_octets, n_size_octets;
    logic [3:0]        r_bytes_seen, n_bytes_seen;

    logic [BYTE_W-1:0] b;
    logic [2:0]        lz;
    logic              done;
    logic              invalid;

    always_comb begin
        b             = i_word.data_byte;
        lz            = lead_zeros(b);
        n_phase       = r_phase;
        n_octets_left = r_octets_left;
        n_id          = r_id;
        n_size        = r_size;
        n_size_octets = r_size_octets;
        n_bytes_seen  = r_bytes_seen;
        done          = 1'b0;
        invalid       = 1'b0;
        case (r_phase)
            PH_ID_LEAD: begin
                if (b == '0 || (4'(lz) + 4'd1) > 4'(MAX_ID_OCTETS)) begin
                    invalid = 1'b1;
                end else begin
                    n_id          = {{(ID_W-BYTE_W){1'b0}}, b};
                    n_octets_left = lz;
                    n_bytes_seen  = 4'd1;
                    n_phase       = (lz == 3'd0) ? PH_SIZE_LEAD : PH_ID_CONT;
                end
            end
            PH_ID_CONT: begin
                n_id          = {r_id[ID_W-BYTE_W-1:0], b};
                n_octets_left = r_octets_left - 3'd1;
                n_bytes_seen  = r_bytes_seen + 4'd1;
                if (r_octets_left == 3'd1) begin
                    n_phase = PH_SIZE_LEAD;
                end
            end
            PH_SIZE_LEAD: begin
                if (b == '0 || (4'(lz) + 4'd1) > 4'(MAX_SIZE_OCTETS)) begin
                    invalid = 1'b1;
                end else begin
                    n_size        = {{(SIZE_W-BYTE_W){1'b0}}, b & ~(8'h80 >> lz)};
                    n_size_octets = 4'(lz) + 4'd1;
                    n_octets_left = lz;
                    n_bytes_seen  = r_bytes_seen + 4'd1;
                    if (lz == 3'd0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_SIZE_CONT;
                    end
                end
            end
            PH_SIZE_CONT: begin
                n_size        = {r_size[SIZE_W-BYTE_W-1:0], b};
                n_octets_left = r_octets_left - 3'd1;
                n_bytes_seen  = r_bytes_seen + 4'd1;
                if (r_octets_left == 3'd1) begin
                    done = 1'b1;
                end
            end
            default: begin
                n_phase = PH_ID_LEAD;
            end
        endcase

        o_res_valid = invalid || done || i_word.buffer_end;
        o_res       = '0;
        if (invalid) begin
            o_res.status = ST_INVALID;
        end else if (done) begin
            o_res.elem_id       = n_id;
            o_res.header_length = n_bytes_seen;
            o_res.status        = ST_OK;
            if (n_size == size_all_ones(n_size_octets)) begin
                o_res.payload_size = '1;
                o_res.size_unknown = 1'b1;
            end else begin
                o_res.payload_size = n_size;
            end
        end else begin
            o_res.status = ST_INCOMPLETE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_res_valid)) begin
            r_phase       <= PH_ID_LEAD;
            r_octets_left <= '0;
            r_id          <= '0;
            r_size        <= '0;
            r_size_octets <= '0;
            r_bytes_seen  <= '0;
        end else if (i_valid) begin
            r_phase       <= n_phase;
            r_octets_left <= n_octets_left;
            r_id          <= n_id;
            r_size        <= n_size;
            r_size_octets <= n_size_octets;
            r_bytes_seen  <= n_bytes_seen;
        end
    end
endmodule

// ===== hdl/ehp_out_stage.sv =====
module ehp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_res_valid,
    input  ehp_pkg::t_out_word i_res,
    output logic               o_ready,
    ehp_out_if.source          o_out
);
    import ehp_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_ready     = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_res_valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_word <= i_res;
        end
    end
endmodule

// ===== hdl/ebml_element_header_parser.sv =====
// Flow: a header byte taken into the input register is decoded combinationally there,
// and its result word is registered in the result register, which presents it at o_out.
// Throughput: one byte per cycle unless o_out stalls, set by both stage registers.
// Reset: synchronous, active low; clears both stage valids and the parser state, so
// the first byte after reset is taken as an ID lead byte.
module ebml_element_header_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ehp_in_if.sink    i_in,
    ehp_out_if.source o_out
);
    import ehp_pkg::*;
    `include "ebml_element_header_parser_defines.svh"

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      s2_ready;
    logic      advance;
    logic      res_valid;
    t_out_word res;
    logic      out_ok;
    logic      out_bad;
    logic      out_unk;
    logic      bad_zeroed;
    logic      ok_len_fits;
    logic      unknown_ones;

    assign advance    = r_in_valid && s2_ready;
    assign i_in.ready = !r_in_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.data;
        end
    end

    ehp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_word      (r_in_word),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ehp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (s2_ready),
        .o_out       (o_out)
    );

    assign out_ok       = o_out.valid && o_out.data.status == ST_OK;
    assign out_bad      = o_out.valid && o_out.data.status != ST_OK;
    assign out_unk      = o_out.valid && o_out.data.size_unknown;
    assign bad_zeroed   = o_out.data.elem_id == '0 && o_out.data.header_length == '0;
    assign ok_len_fits  = o_out.data.header_length >= 4'd2 && o_out.data.header_length <= 4'd12;
    assign unknown_ones = o_out.data.status == ST_OK && o_out.data.payload_size == '1;

    `EHP_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !s2_ready, r_in_valid)
    `EHP_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, out_bad, bad_zeroed)
    `EHP_ASSERT_SAME(a_ok_len, i_clk, i_rst_n, out_ok, ok_len_fits)
    `EHP_ASSERT_SAME(a_unknown, i_clk, i_rst_n, out_unk, unknown_ones)
endmodule

// ===== dv/ebml_element_header_parser_checker.sv =====
`timescale 1ns / 100ps

module ebml_element_header_parser_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ehp_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ehp_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_ok_count,
    output int                 o_cut_count,
    output int                 o_bad_count
);
    import ehp_pkg::*;

    t_phase            hdr_phase;
    logic [3:0]        bytes_to_go;
    logic [ID_W-1:0]   id_value;
    logic [SIZE_W-1:0] size_value;
    logic [3:0]        size_len;
    logic [3:0]        hdr_len;
    t_out_word         header_queue[$];

    function automatic int count_lead_zeros(input logic [BYTE_W-1:0] b);
        int n;
        n = 0;
        while (n < 7 && !b[BYTE_W-1-n]) begin
            n++;
        end
        return n;
    endfunction

    task automatic clear_decoder();
        hdr_phase   = PH_ID_LEAD;
        bytes_to_go = '0;
        id_value    = '0;
        size_value  = '0;
        size_len    = '0;
        hdr_len     = '0;
    endtask

    task automatic decode_byte(input t_in_word w);
        t_out_word   res;
        logic        has_res;
        logic        done;
        int          lz;
        logic [63:0] full;
        res     = '0;
        has_res = 1'b0;
        done    = 1'b0;
        lz      = count_lead_zeros(w.data_byte);
        case (hdr_phase)
            PH_ID_LEAD: begin
                if (w.data_byte == '0 || lz + 1 > MAX_ID_OCTETS) begin
                    res.status = ST_INVALID;
                    has_res    = 1'b1;
                end else begin
                    id_value    = ID_W'(w.data_byte);
                    bytes_to_go = 4'(lz);
                    hdr_len     = 4'd1;
                    hdr_phase   = (lz == 0) ? PH_SIZE_LEAD : PH_ID_CONT;
                end
            end
            PH_ID_CONT: begin
                id_value    = {id_value[ID_W-BYTE_W-1:0], w.data_byte};
                bytes_to_go = bytes_to_go - 4'd1;
                hdr_len     = hdr_len + 4'd1;
                if (bytes_to_go == 0) begin
                    hdr_phase = PH_SIZE_LEAD;
                end
            end
            PH_SIZE_LEAD: begin
                if (w.data_byte == '0 || lz + 1 > MAX_SIZE_OCTETS) begin
                    res.status = ST_INVALID;
                    has_res    = 1'b1;
                end else begin
                    size_value  = SIZE_W'(w.data_byte & ~(8'h80 >> lz));
                    size_len    = 4'(lz + 1);
                    bytes_to_go = 4'(lz);
                    hdr_len     = hdr_len + 4'd1;
                    if (lz == 0) begin
                        done = 1'b1;
                    end else begin
                        hdr_phase = PH_SIZE_CONT;
                    end
                end
            end
            default: begin
                size_value  = {size_value[SIZE_W-BYTE_W-1:0], w.data_byte};
                bytes_to_go = bytes_to_go - 4'd1;
                hdr_len     = hdr_len + 4'd1;
                if (bytes_to_go == 0) begin
                    done = 1'b1;
                end
            end
        endcase
        if (done) begin
            full              = (64'd1 << (VINT_BITS * int'(size_len))) - 64'd1;
            res.elem_id       = id_value;
            res.header_length = hdr_len;
            res.status        = ST_OK;
            if ({8'd0, size_value} == full) begin
                res.payload_size = '1;
                res.size_unknown = 1'b1;
            end else begin
                res.payload_size = size_value;
            end
            has_res = 1'b1;
        end else if (!has_res && w.buffer_end) begin
            res.status = ST_INCOMPLETE;
            has_res    = 1'b1;
        end
        if (has_res) begin
            header_queue.push_back(res);
            clear_decoder();
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clear_decoder();
            header_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (header_queue.size() == 0) begin
                    $display("%0t: result word %h with none expected", $time, i_out_word);
                    o_fail_count++;
                end else begin
                    want = header_queue.pop_front();
                    check_field("elem_id", 64'(want.elem_id), 64'(i_out_word.elem_id));
                    check_field("payload_size", 64'(want.payload_size),
                                64'(i_out_word.payload_size));
                    check_field("size_unknown", 64'(want.size_unknown),
                                64'(i_out_word.size_unknown));
                    check_field("header_length", 64'(want.header_length),
                                64'(i_out_word.header_length));
                    check_field("status", 64'(want.status), 64'(i_out_word.status));
                    case (want.status)
                        ST_OK:         o_ok_count++;
                        ST_INCOMPLETE: o_cut_count++;
                        default:       o_bad_count++;
                    endcase
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_word);
            end
        end
        o_pending = header_queue.size();
    end

endmodule

// ===== dv/ebml_element_header_parser_tb.sv =====
`timescale 1ns / 100ps

module ebml_element_header_parser_tb;
    import ehp_pkg::*;

    localparam int N_BYTES      = 1000;
    localparam int MAX_GAP      = 13;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   cycle_count;
    int   bytes_sent;
    int   fail_count;
    int   pending;
    int   ok_count;
    int   cut_count;
    int   bad_count;

    logic [8:0] opening [24] = '{
        {8'h1A, 1'b0}, {8'h45, 1'b0}, {8'hDF, 1'b0}, {8'hA3, 1'b0}, {8'h9F, 1'b0},
        {8'h80, 1'b0}, {8'hFF, 1'b0},
        {8'h00, 1'b0},
        {8'h08, 1'b0},
        {8'hFF, 1'b0}, {8'h01, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
        {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
        {8'h81, 1'b0}, {8'h00, 1'b0},
        {8'h42, 1'b1},
        {8'h00, 1'b1},
        {8'h81, 1'b0}, {8'h85, 1'b1}
    };

    ehp_in_if  in_ch();
    ehp_out_if out_ch();

    ebml_element_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ebml_element_header_parser_checker header_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_word    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_word   (out_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ok_count   (ok_count),
        .o_cut_count  (cut_count),
        .o_bad_count  (bad_count)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {b, last};
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_header();
        int         id_len;
        int         size_len;
        int         total;
        int         cut_at;
        int         k;
        logic       unknown_size;
        logic [7:0] marker;
        logic [7:0] hdr [12];
        id_len       = ($urandom_range(0, 2) == 0) ? MAX_ID_OCTETS
                                                   : $urandom_range(1, MAX_ID_OCTETS);
        size_len     = ($urandom_range(0, 5) == 0) ? MAX_SIZE_OCTETS : $urandom_range(1, 4);
        unknown_size = ($urandom_range(0, 7) == 0);
        marker       = 8'h80 >> (id_len - 1);
        hdr[0]       = marker | (8'($urandom) & (marker - 8'd1));
        for (k = 1; k < id_len; k++) begin
            hdr[k] = 8'($urandom);
        end
        marker = 8'h80 >> (size_len - 1);
        hdr[id_len] = unknown_size ? (8'hFF >> (size_len - 1))
                                   : (marker | (8'($urandom) & (marker - 8'd1)));
        for (k = id_len + 1; k < id_len + size_len; k++) begin
            hdr[k] = unknown_size ? 8'hFF : 8'($urandom);
        end
        total = id_len + size_len;
        if ($urandom_range(0, 15) == 0) begin
            hdr[id_len] = 8'h00;
            total       = id_len + 1;
        end
        cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
        for (k = 0; k < total && k <= cut_at; k++) begin
            send_byte(hdr[k], (k == cut_at) || (k == total - 1 && $urandom_range(0, 5) == 0));
        end
    endtask

    // end on a byte with buffer_end set so the decoder is back at an ID lead byte
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            n--;
            send_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                      n == 0);
        end
    endtask

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        no_idle      = 1'b0;
        bytes_sent   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) begin
            send_byte(opening[i][8:1], opening[i][0]);
        end

        while (bytes_sent < N_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 7) == 0) begin
                send_noise();
            end else begin
                send_header();
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d stream bytes under random gaps and stalls", bytes_sent);
        $display("results: %0d headers decoded, %0d cut off, %0d rejected",
                 ok_count, cut_count, bad_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
